// File: hw/rtl/mo3_pkg.sv
// ----------------------------------------------------------------------------
// mo3_pkg
// Shared types and constants for the 3x3 orthonormalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mo3_pkg;

  localparam int FIELD_W = 16;
  localparam int MAG_W   = 15;

  typedef logic signed [FIELD_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

endpackage

`default_nettype wire

// File: hw/rtl/mo3_norm.sv
// ----------------------------------------------------------------------------
// mo3_norm
// Pipelined 3-vector normalizer: abs and range scan, common pre-shift,
// squares and length, restoring divide per lane, digit-recurrence square
// root, sign restore. A sideband word rides along with each vector.
// ----------------------------------------------------------------------------
`default_nettype none

module mo3_norm #(
  parameter int IW            = 16,
  parameter int SW            = 1,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic signed [IW-1:0] in_x,
  input  wire logic signed [IW-1:0] in_y,
  input  wire logic signed [IW-1:0] in_z,
  input  wire logic [SW-1:0]        in_sb,
  output logic                      out_valid,
  output mo3_pkg::vec_t             out_vec,
  output logic                      out_zero,
  output logic [SW-1:0]             out_sb
);

  localparam int MW  = mo3_pkg::MAG_W;
  localparam int FW  = mo3_pkg::FIELD_W;
  localparam int SQW = 2 * MW;
  localparam int LW  = SQW + 2;
  localparam int QW  = 2 * OUT_FRAC_BITS + 1;
  localparam int RW  = OUT_FRAC_BITS + 1;
  localparam int SHW = $clog2(IW + 1);
  localparam int NS  = 6 + QW + RW;

  logic                 v_r    [1:NS];
  logic [SW-1:0]        sb_r   [1:NS];
  logic [2:0]           neg_r  [1:NS-1];
  logic                 zero_r [5:NS];

  logic signed [IW-1:0] c_in   [3];
  logic [IW-1:0]        mag1_r [3];
  logic [IW-1:0]        or1_r;
  logic [IW-1:0]        mag2_r [3];
  logic [SHW-1:0]       sh2_r;
  logic [SHW-1:0]       sh_c;
  logic [MW-1:0]        m3_r   [3];
  logic [SQW-1:0]       sq4_r  [3];
  logic [LW-1:0]        len_c;
  logic [LW-1:0]        len_r  [0:QW-1];
  logic [LW-1:0]        rem_r  [0:QW][3];
  logic                 nb_r   [3];
  logic [QW-1:0]        quo_r  [1:QW][3];
  logic [QW-1:0]        sv_r   [1:RW][3];
  logic [QW-1:0]        rs_r   [1:RW][3];
  mo3_pkg::comp_t       o_r    [3];

  assign c_in[0] = in_x;
  assign c_in[1] = in_y;
  assign c_in[2] = in_z;

  // valid and sideband travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[1] <= in_sb;
    end
  end

  for (genvar p = 2; p <= NS; p++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[p] <= 1'b0;
      end else if (adv) begin
        v_r[p] <= v_r[p-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sb_r[p] <= sb_r[p-1];
      end
    end
    if (p < NS) begin : g_neg
      always_ff @(posedge clk) begin
        if (adv) begin
          neg_r[p] <= neg_r[p-1];
        end
      end
    end
    if (p > 5) begin : g_zero
      always_ff @(posedge clk) begin
        if (adv) begin
          zero_r[p] <= zero_r[p-1];
        end
      end
    end
  end

  // stage 1: magnitudes and their OR
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[1][i] <= c_in[i][IW-1];
        mag1_r[i]   <= c_in[i][IW-1] ? IW'(-c_in[i]) : IW'(c_in[i]);
      end
      or1_r <= (c_in[0][IW-1] ? IW'(-c_in[0]) : IW'(c_in[0])) |
               (c_in[1][IW-1] ? IW'(-c_in[1]) : IW'(c_in[1])) |
               (c_in[2][IW-1] ? IW'(-c_in[2]) : IW'(c_in[2]));
    end
  end

  // stage 2: common right shift
  always_comb begin
    sh_c = '0;
    for (int i = MW; i < IW; i++) begin
      if (or1_r[i]) begin
        sh_c = SHW'(i - MW + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2_r <= mag1_r;
      sh2_r  <= sh_c;
    end
  end

  // stage 3: shifted magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m3_r[i] <= MW'(mag2_r[i] >> sh2_r);
      end
    end
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= m3_r[i] * m3_r[i];
      end
    end
  end

  // stage 5: squared length and divider seed
  assign len_c = LW'(sq4_r[0]) + LW'(sq4_r[1]) + LW'(sq4_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r[0]  <= len_c;
      zero_r[5] <= (len_c == '0);
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= LW'(sq4_r[i] >> 1);
        nb_r[i]     <= sq4_r[i][0];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [LW:0] t;
      logic [LW:0] d;
      logic        ge;
      always_comb begin
        t  = {rem_r[k-1][i], (k == 1) ? nb_r[i] : 1'b0};
        ge = (t >= {1'b0, len_r[k-1]});
        d  = t - {1'b0, len_r[k-1]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k][i] <= ge ? d[LW-1:0] : t[LW-1:0];
        end
      end
      if (k == 1) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            quo_r[k][i] <= {{(QW-1){1'b0}}, ge};
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            quo_r[k][i] <= {quo_r[k-1][i][QW-2:0], ge};
          end
        end
      end
    end
    if (k < QW) begin : g_len
      always_ff @(posedge clk) begin
        if (adv) begin
          len_r[k] <= len_r[k-1];
        end
      end
    end
  end

  // square root, one result bit per stage
  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int BS = 2 * OUT_FRAC_BITS - 2 * (j - 1);
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [QW-1:0] sv_in;
      logic [QW-1:0] rs_in;
      logic [QW-1:0] bitv;
      logic [QW:0]   sum;
      logic          ge;
      if (j == 1) begin : g_first
        assign sv_in = quo_r[QW][i];
        assign rs_in = '0;
      end else begin : g_next
        assign sv_in = sv_r[j-1][i];
        assign rs_in = rs_r[j-1][i];
      end
      always_comb begin
        bitv = QW'(1) << BS;
        sum  = {1'b0, rs_in} + {1'b0, bitv};
        ge   = ({1'b0, sv_in} >= sum);
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sv_r[j][i] <= ge ? (sv_in - sum[QW-1:0]) : sv_in;
          rs_r[j][i] <= ge ? ((rs_in >> 1) + bitv) : (rs_in >> 1);
        end
      end
    end
  end

  // output stage: clamp, sign restore, zero vector
  always_ff @(posedge clk) begin
    logic [RW-1:0] r;
    logic [RW-1:0] lim;
    if (adv) begin
      lim = RW'(1) << OUT_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
        r = rs_r[RW][i][RW-1:0];
        if (r > lim) begin
          r = lim;
        end
        if (zero_r[NS-1]) begin
          o_r[i] <= '0;
        end else if (neg_r[NS-1][i]) begin
          o_r[i] <= -FW'(r);
        end else begin
          o_r[i] <= FW'(r);
        end
      end
    end
  end

  assign out_valid = v_r[NS];
  assign out_sb    = sb_r[NS];
  assign out_zero  = zero_r[NS];

  always_comb begin
    out_vec.x = o_r[0];
    out_vec.y = o_r[1];
    out_vec.z = o_r[2];
  end

endmodule

`default_nettype wire

// File: hw/rtl/matrix_orthonormalize_3x3.sv
// Throughput: one word per cycle; the per-lane bit-serial divider and root stages
// of the two normalizers set the depth. A stalled output freezes the whole pipe.
// Reset: synchronous active-low rst_n clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// matrix_orthonormalize_3x3
// Rebuilds three orthonormal Q1.14 axes from the first two Q3.12 rows:
// axis one = unit(row one), axis two = unit(row two x axis one),
// axis three = axis two x axis one, rounded and clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_orthonormalize_3x3 #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_first_row_x,
  input  wire logic signed [15:0] in_first_row_y,
  input  wire logic signed [15:0] in_first_row_z,
  input  wire logic signed [15:0] in_second_row_x,
  input  wire logic signed [15:0] in_second_row_y,
  input  wire logic signed [15:0] in_second_row_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_axis_one_x,
  output logic signed [15:0]      out_axis_one_y,
  output logic signed [15:0]      out_axis_one_z,
  output logic signed [15:0]      out_axis_two_x,
  output logic signed [15:0]      out_axis_two_y,
  output logic signed [15:0]      out_axis_two_z,
  output logic signed [15:0]      out_axis_three_x,
  output logic signed [15:0]      out_axis_three_y,
  output logic signed [15:0]      out_axis_three_z,
  output logic                    out_degenerate
);

  localparam int FW = mo3_pkg::FIELD_W;
  localparam int PW = 2 * FW;
  localparam int AW = 3 * FW;

  logic adv;

  logic                 va;
  mo3_pkg::vec_t        n1_a;
  logic                 z_a;
  logic [AW-1:0]        r2_a;

  logic                 v_c1_r, v_c2_r;
  logic signed [PW-1:0] p_r [6];
  mo3_pkg::vec_t        n1_c1_r, n1_c2_r;
  logic                 dg_c1_r, dg_c2_r;
  logic signed [PW-1:0] x_r [3];

  logic                 vb;
  mo3_pkg::vec_t        n2_b;
  logic                 z_b;
  logic [AW:0]          sb_b;
  mo3_pkg::vec_t        n1_b;
  logic                 dg_b;

  logic                 v_d1_r, v_d2_r, out_valid_r;
  logic signed [PW-1:0] q_r [6];
  logic signed [PW-1:0] w_r [3];
  mo3_pkg::vec_t        n1_d1_r, n1_d2_r, n2_d1_r, n2_d2_r;
  logic                 dg_d1_r, dg_d2_r;
  mo3_pkg::vec_t        a1_r, a2_r, a3_r;
  logic                 dg_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  mo3_norm #(
    .IW            (FW),
    .SW            (AW),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_norm_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_x      (in_first_row_x),
    .in_y      (in_first_row_y),
    .in_z      (in_first_row_z),
    .in_sb     ({in_second_row_x, in_second_row_y, in_second_row_z}),
    .out_valid (va),
    .out_vec   (n1_a),
    .out_zero  (z_a),
    .out_sb    (r2_a)
  );

  // row two x axis one: products, then differences
  always_ff @(posedge clk) begin
    logic signed [FW-1:0] rx, ry, rz;
    if (adv) begin
      rx = r2_a[3*FW-1:2*FW];
      ry = r2_a[2*FW-1:FW];
      rz = r2_a[FW-1:0];
      p_r[0]  <= PW'(ry * n1_a.z);
      p_r[1]  <= PW'(rz * n1_a.y);
      p_r[2]  <= PW'(rz * n1_a.x);
      p_r[3]  <= PW'(rx * n1_a.z);
      p_r[4]  <= PW'(rx * n1_a.y);
      p_r[5]  <= PW'(ry * n1_a.x);
      n1_c1_r <= n1_a;
      dg_c1_r <= z_a;
      x_r[0]  <= p_r[0] - p_r[1];
      x_r[1]  <= p_r[2] - p_r[3];
      x_r[2]  <= p_r[4] - p_r[5];
      n1_c2_r <= n1_c1_r;
      dg_c2_r <= dg_c1_r;
    end
  end

  mo3_norm #(
    .IW            (PW),
    .SW            (AW + 1),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_norm_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v_c2_r),
    .in_x      (x_r[0]),
    .in_y      (x_r[1]),
    .in_z      (x_r[2]),
    .in_sb     ({n1_c2_r, dg_c2_r}),
    .out_valid (vb),
    .out_vec   (n2_b),
    .out_zero  (z_b),
    .out_sb    (sb_b)
  );

  assign n1_b = sb_b[AW:1];
  assign dg_b = sb_b[0];

  // axis two x axis one, round half away from zero, clamp
  always_ff @(posedge clk) begin
    logic          ng;
    logic [PW-1:0] m;
    logic [PW-1:0] lim;
    logic signed [FW-1:0] rv [3];
    if (adv) begin
      q_r[0]  <= PW'(n2_b.y * n1_b.z);
      q_r[1]  <= PW'(n2_b.z * n1_b.y);
      q_r[2]  <= PW'(n2_b.z * n1_b.x);
      q_r[3]  <= PW'(n2_b.x * n1_b.z);
      q_r[4]  <= PW'(n2_b.x * n1_b.y);
      q_r[5]  <= PW'(n2_b.y * n1_b.x);
      n1_d1_r <= n1_b;
      n2_d1_r <= n2_b;
      dg_d1_r <= dg_b | z_b;
      w_r[0]  <= q_r[0] - q_r[1];
      w_r[1]  <= q_r[2] - q_r[3];
      w_r[2]  <= q_r[4] - q_r[5];
      n1_d2_r <= n1_d1_r;
      n2_d2_r <= n2_d1_r;
      dg_d2_r <= dg_d1_r;
      lim = PW'(1) << OUT_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
        ng = w_r[i][PW-1];
        m  = ng ? PW'(-w_r[i]) : PW'(w_r[i]);
        m  = (m + (PW'(1) << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS;
        if (m > lim) begin
          m = lim;
        end
        rv[i] = ng ? -FW'(m) : FW'(m);
      end
      a3_r <= '{x: rv[0], y: rv[1], z: rv[2]};
      a1_r <= n1_d2_r;
      a2_r <= n2_d2_r;
      dg_r <= dg_d2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c1_r      <= 1'b0;
      v_c2_r      <= 1'b0;
      v_d1_r      <= 1'b0;
      v_d2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_c1_r      <= va;
      v_c2_r      <= v_c1_r;
      v_d1_r      <= vb;
      v_d2_r      <= v_d1_r;
      out_valid_r <= v_d2_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_axis_one_x   = a1_r.x;
  assign out_axis_one_y   = a1_r.y;
  assign out_axis_one_z   = a1_r.z;
  assign out_axis_two_x   = a2_r.x;
  assign out_axis_two_y   = a2_r.y;
  assign out_axis_two_z   = a2_r.z;
  assign out_axis_three_x = a3_r.x;
  assign out_axis_three_y = a3_r.y;
  assign out_axis_three_z = a3_r.z;
  assign out_degenerate   = dg_r;

endmodule

`default_nettype wire

// File: hw/rtl/mo3_checker.sv
// ----------------------------------------------------------------------------
// mo3_checker
// Port-level checks for the orthonormalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mo3_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [15:0] in_first_row_x,
  input wire logic signed [15:0] in_first_row_y,
  input wire logic signed [15:0] in_first_row_z,
  input wire logic signed [15:0] in_second_row_x,
  input wire logic signed [15:0] in_second_row_y,
  input wire logic signed [15:0] in_second_row_z,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_axis_one_x,
  input wire logic signed [15:0] out_axis_one_y,
  input wire logic signed [15:0] out_axis_one_z,
  input wire logic signed [15:0] out_axis_two_x,
  input wire logic signed [15:0] out_axis_two_y,
  input wire logic signed [15:0] out_axis_two_z,
  input wire logic signed [15:0] out_axis_three_x,
  input wire logic signed [15:0] out_axis_three_y,
  input wire logic signed [15:0] out_axis_three_z,
  input wire logic               out_degenerate
);

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid &&
      $stable({out_axis_one_x, out_axis_one_y, out_axis_one_z,
               out_axis_two_x, out_axis_two_y, out_axis_two_z,
               out_axis_three_x, out_axis_three_y, out_axis_three_z,
               out_degenerate})))
    else $error("stalled output word changed");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_axis_one_x <= 16'sd16384 && out_axis_one_x >= -16'sd16384 &&
                   out_axis_two_y <= 16'sd16384 && out_axis_two_y >= -16'sd16384 &&
                   out_axis_three_z <= 16'sd16384 && out_axis_three_z >= -16'sd16384))
    else $error("axis component beyond unit range");

  a_zero_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_axis_one_x == 16'sd0 && out_axis_one_y == 16'sd0 &&
     out_axis_one_z == 16'sd0) |->
    (out_degenerate && out_axis_two_x == 16'sd0 && out_axis_two_y == 16'sd0 &&
     out_axis_two_z == 16'sd0 && out_axis_three_x == 16'sd0 &&
     out_axis_three_y == 16'sd0 && out_axis_three_z == 16'sd0))
    else $error("zero axis one without degenerate zero result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind matrix_orthonormalize_3x3 mo3_checker u_mo3_checker (.*);

`default_nettype wire
